### src/bsfdt_pkg.sv
// Shared types and constants for the load-cell bridge frame handler.
package bsfdt_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [1:0]  FUNC_READ   = 2'd0;
	localparam logic [1:0]  FUNC_BUSERR = 2'd1;
	localparam logic [1:0]  FUNC_TARE   = 2'd2;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;

	localparam logic [1:0]  ST_GOOD  = 2'd0;
	localparam logic [1:0]  ST_BAD1  = 2'd1;
	localparam logic [1:0]  ST_STALE = 2'd2;
	localparam logic [1:0]  ST_BAD3  = 2'd3;

	localparam logic [13:0] ZERO_RESET = 14'd950;
	// x * 5000 / 14000 == (x * 374495) >> 20 for all 14-bit x
	localparam logic [32:0] W_RECIP    = 33'd374495;
	localparam int          W_SHIFT    = 20;
	// x * 2000 / 2048 == (x * 125) >> 7
	localparam logic [17:0] T_MUL      = 18'd125;
	localparam int          T_SHIFT    = 7;
	localparam logic signed [11:0] T_OFFSET = 12'sd500;
	localparam logic [12:0] W_MAX      = 13'd5851;

	typedef enum logic [2:0] {
		OP_GOOD   = 3'd0,
		OP_STALE  = 3'd1,
		OP_BAD    = 3'd2,
		OP_BUSERR = 3'd3,
		OP_TARE   = 3'd4,
		OP_NONE   = 3'd5,
		OP_IGNORE = 3'd6
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  channel;
		logic [31:0] frame;
	} req_t;

	typedef struct packed {
		logic [1:0]         out_channel;
		logic               sample_valid;
		logic [12:0]        weight_centi_kg;
		logic signed [11:0] temp_deci_c;
		logic [31:0]        good_count;
		logic [31:0]        stale_count;
		logic [31:0]        bad_status_count;
		logic [31:0]        bus_error_count;
	} rsp_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  channel;
		logic [13:0] raw_w;
		logic [10:0] raw_t;
	} item_t;

endpackage

### src/bridge_sensor_frame_decode_tare_core.sv
// Top level of the four-channel load-cell bridge frame handler.
//
// Request channel (req_valid/req_ready/req): one transaction per bus event
// on a channel: a completed frame read, a failed read, or a tare request.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
// request, in order, carrying the channel's counters and, for a good
// sample, the tared weight and the temperature.
// A request is written into the queue at the accepting edge, then passes
// the state update stage and the scaling/output register before its
// response is valid.
// Throughput: one transaction per cycle while the receiver accepts
// responses, set by the per-channel state update in the back end.
// Reset: all counters and tare arms clear, every zero level returns to 950;
// the user must send no request while reset is asserted (not enforced).
// A stalled receiver holds the response; the two-entry queue and the
// pipeline absorb up to four transactions before req_ready falls.
module bridge_sensor_frame_decode_tare_core
	import bsfdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	item_t front_item;
	item_t head;
	logic  q_full, q_not_empty, pop;

	assign req_ready = !q_full;

	bsfdt_front u_front (
		.req  (req),
		.item (front_item)
	);

	bsfdt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_valid && !q_full),
		.push_item (front_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	bsfdt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

### src/bsfdt_front.sv
// Front end: classifies an incoming transaction into a queue entry.
module bsfdt_front
	import bsfdt_pkg::*;
(
	input  req_t  req,
	output item_t item
);

	always_comb begin
		item.channel = req.channel;
		item.raw_w   = req.frame[29:16];
		item.raw_t   = req.frame[15:5];
		item.op      = OP_NONE;
		if (32'(req.channel) >= CHANNELS) begin
			item.op = OP_IGNORE;
		end else begin
			unique case (req.func)
				FUNC_READ: begin
					unique case (req.frame[31:30])
						ST_GOOD:  item.op = OP_GOOD;
						ST_STALE: item.op = OP_STALE;
						ST_BAD1:  item.op = OP_BAD;
						ST_BAD3:  item.op = OP_BAD;
					endcase
				end
				FUNC_BUSERR: item.op = OP_BUSERR;
				FUNC_TARE:   item.op = OP_TARE;
				FUNC_UNUSED: item.op = OP_NONE;
			endcase
		end
	end

endmodule

### src/bsfdt_queue.sv
// Short queue between the front end and the state/result back end.
module bsfdt_queue
	import bsfdt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

endmodule

### src/bsfdt_back.sv
// Back end: per-channel state update, then weight/temperature scaling into the output register.
module bsfdt_back
	import bsfdt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  head_valid,
	input  item_t head,
	output logic  pop,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	logic [13:0] zero_q  [CHANNELS];
	logic        armed_q [CHANNELS];
	logic [31:0] good_q  [CHANNELS];
	logic [31:0] stale_q [CHANNELS];
	logic [31:0] bad_q   [CHANNELS];
	logic [31:0] err_q   [CHANNELS];

	logic [CH_IDX_W-1:0] idx;
	logic                s1_ready, s2_ready;
	logic                is_good, is_ignore;
	logic [31:0]         good_nx, stale_nx, bad_nx, err_nx;
	logic [13:0]         zero_eff;

	logic                v_s1;
	logic [1:0]          ch_s1;
	logic                sv_s1;
	logic [13:0]         diff_s1;
	logic [10:0]         raw_t_s1;
	logic [31:0]         good_s1, stale_s1, bad_s1, err_s1;

	logic                v_s2;
	rsp_t                rsp_s2;

	logic [32:0]         wprod;
	logic [17:0]         tprod;

	assign idx       = CH_IDX_W'(head.channel);
	assign s2_ready  = !v_s2 || rsp_ready;
	assign s1_ready  = !v_s1 || s2_ready;
	assign pop       = head_valid && s1_ready;
	assign is_good   = (head.op == OP_GOOD);
	assign is_ignore = (head.op == OP_IGNORE);

	always_comb begin
		good_nx  = good_q[idx]  + 32'((head.op == OP_GOOD));
		stale_nx = stale_q[idx] + 32'((head.op == OP_STALE));
		bad_nx   = bad_q[idx]   + 32'((head.op == OP_BAD));
		err_nx   = err_q[idx]   + 32'((head.op == OP_BUSERR));
		zero_eff = armed_q[idx] ? head.raw_w : zero_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				zero_q[k]  <= ZERO_RESET;
				armed_q[k] <= 1'b0;
				good_q[k]  <= '0;
				stale_q[k] <= '0;
				bad_q[k]   <= '0;
				err_q[k]   <= '0;
			end
		end else if (pop && !is_ignore) begin
			good_q[idx]  <= good_nx;
			stale_q[idx] <= stale_nx;
			bad_q[idx]   <= bad_nx;
			err_q[idx]   <= err_nx;
			if (is_good) begin
				zero_q[idx]  <= zero_eff;
				armed_q[idx] <= 1'b0;
			end else if (head.op == OP_TARE) begin
				armed_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= head_valid;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ch_s1    <= head.channel;
			sv_s1    <= is_good;
			diff_s1  <= (is_good && head.raw_w >= zero_eff) ? head.raw_w - zero_eff : '0;
			raw_t_s1 <= head.raw_t;
			good_s1  <= is_ignore ? '0 : good_nx;
			stale_s1 <= is_ignore ? '0 : stale_nx;
			bad_s1   <= is_ignore ? '0 : bad_nx;
			err_s1   <= is_ignore ? '0 : err_nx;
		end
	end

	assign wprod = 33'(diff_s1) * W_RECIP;
	assign tprod = 18'(raw_t_s1) * T_MUL;

	always_ff @(posedge clk) begin
		if (v_s1 && s2_ready) begin
			rsp_s2.out_channel      <= ch_s1;
			rsp_s2.sample_valid     <= sv_s1;
			rsp_s2.weight_centi_kg  <= wprod[W_SHIFT+12:W_SHIFT];
			rsp_s2.temp_deci_c      <= sv_s1 ?
				$signed({1'b0, tprod[T_SHIFT+10:T_SHIFT]}) - T_OFFSET : '0;
			rsp_s2.good_count       <= good_s1;
			rsp_s2.stale_count      <= stale_s1;
			rsp_s2.bad_status_count <= bad_s1;
			rsp_s2.bus_error_count  <= err_s1;
		end
	end

	assign rsp_valid = v_s2;
	assign rsp       = rsp_s2;

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.weight_centi_kg <= W_MAX)
		else $error("weight beyond scale");

	a_no_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.sample_valid |-> rsp.weight_centi_kg == '0 && rsp.temp_deci_c == '0)
		else $error("non-sample result carries values");

	a_good_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_good |=> good_q[$past(idx)] == $past(good_nx))
		else $error("good counter not advanced");

endmodule
